// ----- rtl/stk_pkg.sv -----
package stk_pkg;

   // Fixed field widths.
   localparam int FIELD_W = 32;
   localparam int CSR_INDEX_W = 3;

   // Saturation range of the momentum sum.
   localparam int DATA_WIDTH = 32;

   // Number of CORDIC iterations; the angle table holds thirty entries.
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN = 30;
   localparam int NUM_CELLS = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int STAGE_IDX_W = 5;
   localparam int ATAN_W = 30;

   // CORDIC datapath widths: x and y in Q2.30 with headroom, z in 2^-32 turns.
   localparam int XY_W = 34;
   localparam int Z_W = 33;
   localparam int SINE_W = 33;
   localparam int PROD_W = FIELD_W + SINE_W;
   localparam int KICK_W = PROD_W - 30;
   localparam int SUM_W = (DATA_WIDTH + 2 > KICK_W + 1) ? DATA_WIDTH + 2 : KICK_W + 1;

   localparam logic signed [XY_W-1:0] INV_GAIN = XY_W'(652032874);
   localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'd1073741824);
   localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(64'd2147483648);

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_KICK_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KICK_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_X = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_Y = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVENUMBER_X = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVENUMBER_Y = 3'd5;

   typedef struct packed {
      logic signed [FIELD_W-1:0] kick_x;
      logic signed [FIELD_W-1:0] kick_y;
      logic [FIELD_W-1:0] phase_x;
      logic [FIELD_W-1:0] phase_y;
      logic signed [FIELD_W-1:0] wavenumber_x;
      logic signed [FIELD_W-1:0] wavenumber_y;
   } cfg_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] path_ct;
      logic signed [FIELD_W-1:0] mom_x_in;
      logic signed [FIELD_W-1:0] mom_y_in;
      logic lost_in;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] mom_x_out;
      logic signed [FIELD_W-1:0] mom_y_out;
      logic lost_out;
   } rsp_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0] z;
   } lane_type;

   // One particle as it travels down the CORDIC chain.
   typedef struct packed {
      lane_type lane_x;
      lane_type lane_y;
      logic neg_x;
      logic neg_y;
      logic signed [FIELD_W-1:0] mom_x;
      logic signed [FIELD_W-1:0] mom_y;
      logic lost;
   } cordic_type;

   // Arctangent of 2^-i in 2^-32 turns.
   function automatic logic [ATAN_W-1:0] atan_step(input logic [STAGE_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] r;
      unique case (idx)
         5'd0: r = 30'd536870912;
         5'd1: r = 30'd316933405;
         5'd2: r = 30'd167458907;
         5'd3: r = 30'd85005780;
         5'd4: r = 30'd42667331;
         5'd5: r = 30'd21354465;
         5'd6: r = 30'd10679838;
         5'd7: r = 30'd5340245;
         5'd8: r = 30'd2670163;
         5'd9: r = 30'd1335086;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41721;
         5'd15: r = 30'd20860;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2607;
         5'd19: r = 30'd1303;
         5'd20: r = 30'd651;
         5'd21: r = 30'd325;
         5'd22: r = 30'd162;
         5'd23: r = 30'd81;
         5'd24: r = 30'd40;
         5'd25: r = 30'd20;
         5'd26: r = 30'd10;
         5'd27: r = 30'd5;
         5'd28: r = 30'd2;
         5'd29: r = 30'd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // One rotation-mode CORDIC iteration.
   function automatic lane_type cordic_step(input lane_type l,
                                            input logic [STAGE_IDX_W-1:0] idx);
      lane_type r;
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [Z_W-1:0] step;
      dx = l.y >>> idx;
      dy = l.x >>> idx;
      step = $signed({{(Z_W-ATAN_W){1'b0}}, atan_step(idx)});
      if (!l.z[Z_W-1]) begin
         r.x = l.x - dx;
         r.y = l.y + dy;
         r.z = l.z - step;
      end else begin
         r.x = l.x + dx;
         r.y = l.y - dy;
         r.z = l.z + step;
      end
      return r;
   endfunction

endpackage

// ----- rtl/stk_if.sv -----
interface stk_req_if;
   logic valid;
   logic ready;
   logic signed [stk_pkg::FIELD_W-1:0] path_ct;
   logic signed [stk_pkg::FIELD_W-1:0] mom_x_in;
   logic signed [stk_pkg::FIELD_W-1:0] mom_y_in;
   logic lost_in;

   modport source (output valid, output path_ct, output mom_x_in, output mom_y_in,
                   output lost_in, input ready);
   modport sink (input valid, input path_ct, input mom_x_in, input mom_y_in,
                 input lost_in, output ready);
endinterface

interface stk_rsp_if;
   logic valid;
   logic ready;
   logic signed [stk_pkg::FIELD_W-1:0] mom_x_out;
   logic signed [stk_pkg::FIELD_W-1:0] mom_y_out;
   logic lost_out;

   modport source (output valid, output mom_x_out, output mom_y_out, output lost_out,
                   input ready);
   modport sink (input valid, input mom_x_out, input mom_y_out, input lost_out,
                 output ready);
endinterface

interface stk_csr_if;
   logic valid;
   logic ready;
   logic [stk_pkg::CSR_INDEX_W-1:0] index;
   logic [stk_pkg::FIELD_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sinusoidal_transverse_kick_core.sv -----
// Channel   Direction  Contents
// req_chan  in         path_ct, mom_x_in, mom_y_in, lost_in
// rsp_chan  out        mom_x_out, mom_y_out, lost_out
// csr_chan  in         index, data (register write)
//
// One request is accepted every cycle while the chain is not backed up; each gives one
// response after two front stages, one CORDIC cell per iteration, a multiply stage
// and the result register.
// Reset is synchronous and clears all valid flags and the six configuration registers.
// Every stage holds its item while the next one is full, so a stalled response
// only blocks the request side once the whole chain has filled up.
module sinusoidal_transverse_kick_core (
   input logic clock,
   input logic reset,
   stk_req_if.sink req_chan,
   stk_rsp_if.source rsp_chan,
   stk_csr_if.sink csr_chan
);

   // Configuration registers. Software folds the turn-dependent terms into
   // the phase and wavenumber values before a bunch is streamed.
   stk_pkg::cfg_type cfg_ff;

   stk_pkg::req_type req_data;
   stk_pkg::rsp_type rsp_data;

   // Handshake and payload links along the chain. Link 0 leaves the front end
   // and link NUM_CELLS enters the back end.
   logic chain_valid [stk_pkg::NUM_CELLS+1];
   logic chain_ready [stk_pkg::NUM_CELLS+1];
   stk_pkg::cordic_type chain_data [stk_pkg::NUM_CELLS+1];

   // The register file never pushes back on writes.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            stk_pkg::CSR_KICK_X: cfg_ff.kick_x <= csr_chan.data;
            stk_pkg::CSR_KICK_Y: cfg_ff.kick_y <= csr_chan.data;
            stk_pkg::CSR_PHASE_X: cfg_ff.phase_x <= csr_chan.data;
            stk_pkg::CSR_PHASE_Y: cfg_ff.phase_y <= csr_chan.data;
            stk_pkg::CSR_WAVENUMBER_X: cfg_ff.wavenumber_x <= csr_chan.data;
            stk_pkg::CSR_WAVENUMBER_Y: cfg_ff.wavenumber_y <= csr_chan.data;
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   always_comb begin
      req_data.path_ct = req_chan.path_ct;
      req_data.mom_x_in = req_chan.mom_x_in;
      req_data.mom_y_in = req_chan.mom_y_in;
      req_data.lost_in = req_chan.lost_in;
   end

   // The front end forms the angle phase - wavenumber*ct and folds it to the
   // range the CORDIC converges on.
   stk_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .in_valid(req_chan.valid),
      .in_ready(req_chan.ready),
      .in_data(req_data),
      .out_valid(chain_valid[0]),
      .out_ready(chain_ready[0]),
      .out_data(chain_data[0])
   );

   // Each cell performs one CORDIC iteration on both planes and hands the
   // particle to its neighbor.
   for (genvar i = 0; i < stk_pkg::NUM_CELLS; i++) begin : g_cell
      stk_cell u_cell (
         .clock(clock),
         .reset(reset),
         .stage_idx(stk_pkg::STAGE_IDX_W'(i)),
         .in_valid(chain_valid[i]),
         .in_ready(chain_ready[i]),
         .in_data(chain_data[i]),
         .out_valid(chain_valid[i+1]),
         .out_ready(chain_ready[i+1]),
         .out_data(chain_data[i+1])
      );
   end

   // The back end scales the sine by the kick, rounds, adds and saturates unless lost.
   stk_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .in_valid(chain_valid[stk_pkg::NUM_CELLS]),
      .in_ready(chain_ready[stk_pkg::NUM_CELLS]),
      .in_data(chain_data[stk_pkg::NUM_CELLS]),
      .out_valid(rsp_chan.valid),
      .out_ready(rsp_chan.ready),
      .out_data(rsp_data)
   );

   assign rsp_chan.mom_x_out = rsp_data.mom_x_out;
   assign rsp_chan.mom_y_out = rsp_data.mom_y_out;
   assign rsp_chan.lost_out = rsp_data.lost_out;

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule

// ----- rtl/stk_front.sv -----
module stk_front (
   input logic clock,
   input logic reset,
   input stk_pkg::cfg_type cfg,
   input logic in_valid,
   output logic in_ready,
   input stk_pkg::req_type in_data,
   output logic out_valid,
   input logic out_ready,
   output stk_pkg::cordic_type out_data
);

   // Stage A: wavenumber times ct.
   logic a_valid_ff;
   logic a_ready;
   logic [stk_pkg::FIELD_W-1:0] a_off_x_ff, a_off_x_in;
   logic [stk_pkg::FIELD_W-1:0] a_off_y_ff, a_off_y_in;
   stk_pkg::req_type a_req_ff;

   // Stage B: phase, quadrant fold and CORDIC start vector.
   logic b_valid_ff;
   logic b_ready;
   stk_pkg::cordic_type b_data_ff, b_data_in;

   logic signed [2*stk_pkg::FIELD_W-1:0] prod_x;
   logic signed [2*stk_pkg::FIELD_W-1:0] prod_y;

   // Folds the angle into a quarter turn either side of zero.
   function automatic stk_pkg::lane_type start_lane(input logic [stk_pkg::FIELD_W-1:0] phase,
                                                    input logic [stk_pkg::FIELD_W-1:0] off,
                                                    output logic neg);
      stk_pkg::lane_type l;
      logic [stk_pkg::FIELD_W-1:0] angle;
      logic signed [stk_pkg::Z_W-1:0] a;
      angle = phase - off;
      a = $signed({angle[stk_pkg::FIELD_W-1], angle});
      neg = 1'b0;
      if (a > stk_pkg::QUARTER_TURN) begin
         a = a - stk_pkg::HALF_TURN;
         neg = 1'b1;
      end else if (a < -stk_pkg::QUARTER_TURN) begin
         a = a + stk_pkg::HALF_TURN;
         neg = 1'b1;
      end
      l.x = stk_pkg::INV_GAIN;
      l.y = '0;
      l.z = a;
      return l;
   endfunction

   assign b_ready = !b_valid_ff || out_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      prod_x = cfg.wavenumber_x * in_data.path_ct;
      prod_y = cfg.wavenumber_y * in_data.path_ct;
      a_off_x_in = prod_x[39:8];
      a_off_y_in = prod_y[39:8];
   end

   always_comb begin
      logic nx;
      logic ny;
      b_data_in.lane_x = start_lane(cfg.phase_x, a_off_x_ff, nx);
      b_data_in.lane_y = start_lane(cfg.phase_y, a_off_y_ff, ny);
      b_data_in.neg_x = nx;
      b_data_in.neg_y = ny;
      b_data_in.mom_x = a_req_ff.mom_x_in;
      b_data_in.mom_y = a_req_ff.mom_y_in;
      b_data_in.lost = a_req_ff.lost_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         a_off_x_ff <= a_off_x_in;
         a_off_y_ff <= a_off_y_in;
         a_req_ff <= in_data;
      end
      if (a_valid_ff && b_ready) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data = b_data_ff;

endmodule

// ----- rtl/stk_cell.sv -----
module stk_cell (
   input logic clock,
   input logic reset,
   input logic [stk_pkg::STAGE_IDX_W-1:0] stage_idx,
   input logic in_valid,
   output logic in_ready,
   input stk_pkg::cordic_type in_data,
   output logic out_valid,
   input logic out_ready,
   output stk_pkg::cordic_type out_data
);

   logic valid_ff;
   stk_pkg::cordic_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in = in_data;
      data_in.lane_x = stk_pkg::cordic_step(in_data.lane_x, stage_idx);
      data_in.lane_y = stk_pkg::cordic_step(in_data.lane_y, stage_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> out_valid)
      else $error("accepted item did not land in the cell");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |-> !in_ready)
      else $error("cell would overwrite a stalled item");

endmodule

// ----- rtl/stk_back.sv -----
module stk_back (
   input logic clock,
   input logic reset,
   input stk_pkg::cfg_type cfg,
   input logic in_valid,
   output logic in_ready,
   input stk_pkg::cordic_type in_data,
   output logic out_valid,
   input logic out_ready,
   output stk_pkg::rsp_type out_data
);

   localparam logic signed [stk_pkg::SUM_W-1:0] SAT_HI =
      {{(stk_pkg::SUM_W-stk_pkg::DATA_WIDTH+1){1'b0}}, {(stk_pkg::DATA_WIDTH-1){1'b1}}};
   localparam logic signed [stk_pkg::SUM_W-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [stk_pkg::PROD_W-1:0] ROUND_HALF = stk_pkg::PROD_W'(64'd536870912);

   // Stage M: kick times sine.
   logic m_valid_ff;
   logic m_ready;
   logic signed [stk_pkg::PROD_W-1:0] m_prod_x_ff, m_prod_x_in;
   logic signed [stk_pkg::PROD_W-1:0] m_prod_y_ff, m_prod_y_in;
   logic signed [stk_pkg::FIELD_W-1:0] m_mom_x_ff;
   logic signed [stk_pkg::FIELD_W-1:0] m_mom_y_ff;
   logic m_lost_ff;

   // Stage O: rounding, sum and saturation into the result register.
   logic o_valid_ff;
   stk_pkg::rsp_type o_data_ff, o_data_in;

   function automatic logic signed [stk_pkg::SINE_W-1:0] sine_of(
      input logic signed [stk_pkg::XY_W-1:0] y, input logic neg);
      logic signed [stk_pkg::XY_W-1:0] s;
      s = neg ? -y : y;
      return s[stk_pkg::SINE_W-1:0];
   endfunction

   function automatic logic signed [stk_pkg::FIELD_W-1:0] kicked(
      input logic signed [stk_pkg::FIELD_W-1:0] mom,
      input logic signed [stk_pkg::PROD_W-1:0] prod);
      logic signed [stk_pkg::PROD_W-1:0] rounded;
      logic signed [stk_pkg::KICK_W-1:0] k;
      logic signed [stk_pkg::SUM_W-1:0] sum;
      rounded = prod + ROUND_HALF;
      k = rounded[stk_pkg::PROD_W-1:30];
      sum = {{(stk_pkg::SUM_W-stk_pkg::FIELD_W){mom[stk_pkg::FIELD_W-1]}}, mom}
          + {{(stk_pkg::SUM_W-stk_pkg::KICK_W){k[stk_pkg::KICK_W-1]}}, k};
      if (sum > SAT_HI) begin
         sum = SAT_HI;
      end else if (sum < SAT_LO) begin
         sum = SAT_LO;
      end
      return sum[stk_pkg::FIELD_W-1:0];
   endfunction

   assign m_ready = !o_valid_ff || out_ready;
   assign in_ready = !m_valid_ff || m_ready;

   always_comb begin
      m_prod_x_in = cfg.kick_x * sine_of(in_data.lane_x.y, in_data.neg_x);
      m_prod_y_in = cfg.kick_y * sine_of(in_data.lane_y.y, in_data.neg_y);
   end

   always_comb begin
      o_data_in.lost_out = m_lost_ff;
      if (m_lost_ff) begin
         o_data_in.mom_x_out = m_mom_x_ff;
         o_data_in.mom_y_out = m_mom_y_ff;
      end else begin
         o_data_in.mom_x_out = kicked(m_mom_x_ff, m_prod_x_ff);
         o_data_in.mom_y_out = kicked(m_mom_y_ff, m_prod_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            m_valid_ff <= in_valid;
         end
         if (m_ready) begin
            o_valid_ff <= m_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         m_prod_x_ff <= m_prod_x_in;
         m_prod_y_ff <= m_prod_y_in;
         m_mom_x_ff <= in_data.mom_x;
         m_mom_y_ff <= in_data.mom_y;
         m_lost_ff <= in_data.lost;
      end
      if (m_valid_ff && m_ready) begin
         o_data_ff <= o_data_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_data = o_data_ff;

   a_product_lands: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> m_valid_ff)
      else $error("accepted item did not reach the multiply stage");

endmodule

// ----- bench/sinusoidal_transverse_kick_core_test.sv -----
// Checks the sinusoidal transverse kick core end to end. A behavioral
// predictor computes the kicked momenta of every accepted request from its own
// copy of the six kick registers, and the response monitor compares each
// response with the oldest prediction. Stimulus starts with a few directed
// checks and then runs random bursts with three idling profiles on the request
// and response channels.
module sinusoidal_transverse_kick_core_test;
   import stk_pkg::*;

   // Number of registers from request to response; the final wait is based on it.
   localparam int PIPE_LATENCY = 4 + NUM_CELLS;
   // Cycles without any handshake before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   // Random requests per register setting.
   localparam int BURST_LEN = 55;
   // Mismatch lines printed before the report goes quiet.
   localparam int PRINT_LIMIT = 100;

   // Register indexes above the six real registers; writes there are dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [FIELD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [FIELD_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [FIELD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;
   localparam logic [FIELD_W-1:0] WORD_ZERO = 32'h0000_0000;
   localparam logic [FIELD_W-1:0] QUARTER_WORD = 32'h4000_0000;
   localparam logic [FIELD_W-1:0] THREE_QUARTER_WORD = 32'hC000_0000;
   // One cycle per metre of ct in Q8.24.
   localparam logic [FIELD_W-1:0] ONE_PER_METRE = 32'h0100_0000;

   // Predictor constants: CORDIC start vector (inverse gain, Q2.30), fold
   // limits in 2^-32 turns, and the rounding offset of the Q35.30 product.
   localparam longint START_X = 64'sd652032874;
   localparam longint QUARTER_TURNS = 64'sd1073741824;
   localparam longint HALF_TURNS = 64'sd2147483648;
   localparam longint ROUND_HALF = 64'sd536870912;

   logic clock;
   logic reset;

   stk_req_if req_chan();
   stk_rsp_if rsp_chan();
   stk_csr_if csr_chan();

   sinusoidal_transverse_kick_core i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // Arctangent of 2^-i, in 2^-32 turns.
   longint arctan_turns [ATAN_LEN] = '{
      536870912, 316933405, 167458907, 85005780, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886, 83443,
      41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
      10, 5, 2, 1
   };

   // Register values as the core should hold them right now.
   cfg_type csr_shadow;
   // Predicted responses, oldest first.
   rsp_type kicked_momenta[$];

   int unsigned mismatches;
   // Per-cycle idle chances, in percent, of the request and response sides.
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Rotation-mode CORDIC sine of an angle in 2^-32 turns. Angles beyond a
   // quarter turn either way are folded by half a turn and the sine negated.
   function automatic longint cordic_sine(input logic [FIELD_W-1:0] angle);
      longint a, x, y, z, dx, dy;
      bit flip;
      a = longint'($signed(angle));
      flip = 1'b0;
      if (a > QUARTER_TURNS) begin
         a = a - HALF_TURNS;
         flip = 1'b1;
      end else if (a < -QUARTER_TURNS) begin
         a = a + HALF_TURNS;
         flip = 1'b1;
      end
      x = START_X;
      y = 0;
      z = a;
      for (int i = 0; i < NUM_CELLS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - arctan_turns[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + arctan_turns[i];
         end
      end
      return flip ? -y : y;
   endfunction

   // One plane: momentum plus kick*sin(2*pi*(phase - wavenumber*ct)). The
   // offset is bits 39..8 of the exact Q24.40 product, so it floors. The kick
   // is rounded from Q35.30 to whole units with ties going up, and the sum clips at the rails.
   function automatic logic [FIELD_W-1:0] kicked_momentum(
      input logic signed [FIELD_W-1:0] mom,
      input logic signed [FIELD_W-1:0] kick,
      input logic [FIELD_W-1:0] phase,
      input logic signed [FIELD_W-1:0] wavenumber,
      input logic signed [FIELD_W-1:0] ct);
      longint prod, sine, kick_q30, sum, rail_hi, rail_lo;
      logic [FIELD_W-1:0] angle;
      prod = longint'(wavenumber) * longint'(ct);
      angle = phase - prod[39:8];
      sine = cordic_sine(angle);
      kick_q30 = (longint'(kick) * sine + ROUND_HALF) >>> 30;
      rail_hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
      rail_lo = -rail_hi - 1;
      sum = longint'(mom) + kick_q30;
      if (sum > rail_hi) begin
         sum = rail_hi;
      end
      if (sum < rail_lo) begin
         sum = rail_lo;
      end
      return sum[FIELD_W-1:0];
   endfunction

   // Lost particles pass through untouched; the others get both kicks.
   function automatic rsp_type kick_particle(input req_type p);
      rsp_type r;
      r.lost_out = p.lost_in;
      if (p.lost_in) begin
         r.mom_x_out = p.mom_x_in;
         r.mom_y_out = p.mom_y_in;
      end else begin
         r.mom_x_out = kicked_momentum(p.mom_x_in, csr_shadow.kick_x, csr_shadow.phase_x,
                                       csr_shadow.wavenumber_x, p.path_ct);
         r.mom_y_out = kicked_momentum(p.mom_y_in, csr_shadow.kick_y, csr_shadow.phase_y,
                                       csr_shadow.wavenumber_y, p.path_ct);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic req_type particle(input logic [FIELD_W-1:0] ct,
                                        input logic [FIELD_W-1:0] px,
                                        input logic [FIELD_W-1:0] py,
                                        input logic lost);
      req_type p;
      p.path_ct = ct;
      p.mom_x_in = px;
      p.mom_y_in = py;
      p.lost_in = lost;
      return p;
   endfunction

   // Momenta sit near either rail half of the time so that saturation is
   // exercised often once the kick amplitude is large.
   function automatic logic [FIELD_W-1:0] random_momentum();
      case ($urandom_range(3))
         0: return WORD_MAX - $urandom_range(255);
         1: return WORD_MIN + $urandom_range(255);
         default: return $urandom;
      endcase
   endfunction

   // A quarter of the requests use a short ct of a few metres; the rest use
   // the whole range so that the phase product wraps freely.
   function automatic req_type random_particle();
      logic [FIELD_W-1:0] r;
      logic [FIELD_W-1:0] ct;
      r = $urandom;
      ct = ($urandom_range(3) == 0) ? {{12{r[31]}}, r[19:0]} : r;
      return particle(ct, random_momentum(), random_momentum(), $urandom_range(7) == 0);
   endfunction

   function automatic logic [FIELD_W-1:0] random_word();
      case ($urandom_range(7))
         0: return WORD_ZERO;
         1: return WORD_MAX;
         2: return WORD_MIN;
         3: return WORD_ONES;
         default: return $urandom;
      endcase
   endfunction

   // Every fifth setting pins all registers at their top values and the one
   // after it at their bottom values; the others are random.
   function automatic cfg_type random_settings(input int unsigned burst);
      cfg_type c;
      case (burst % 5)
         0: c = cfg_type'{kick_x: WORD_MAX, kick_y: WORD_MAX, phase_x: WORD_ONES,
                          phase_y: WORD_ONES, wavenumber_x: WORD_MAX,
                          wavenumber_y: WORD_MAX};
         1: c = cfg_type'{kick_x: WORD_MIN, kick_y: WORD_MIN, phase_x: WORD_ZERO,
                          phase_y: WORD_ZERO, wavenumber_x: WORD_MIN,
                          wavenumber_y: WORD_MIN};
         default: c = cfg_type'{kick_x: random_word(), kick_y: random_word(),
                                phase_x: random_word(), phase_y: random_word(),
                                wavenumber_x: random_word(), wavenumber_y: random_word()};
      endcase
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------

   // Leaves valid high after the handshake so that back-to-back writes never
   // lower and raise it within one time step.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [FIELD_W-1:0] word);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= word;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // Only called while the core is idle. The two spare indexes get random
   // data, which the core must drop.
   task automatic program_registers(input cfg_type c);
      csr_write(CSR_KICK_X, c.kick_x);
      csr_write(CSR_KICK_Y, c.kick_y);
      csr_write(CSR_PHASE_X, c.phase_x);
      csr_write(CSR_PHASE_Y, c.phase_y);
      csr_write(CSR_WAVENUMBER_X, c.wavenumber_x);
      csr_write(CSR_WAVENUMBER_Y, c.wavenumber_y);
      csr_write(CSR_SPARE_LO, $urandom);
      csr_write(CSR_SPARE_HI, $urandom);
      csr_chan.valid <= 1'b0;
      csr_shadow = c;
   endtask

   // Sends one request, idling beforehand at the current request-side rate.
   // The prediction is queued at the edge that accepts the request.
   task automatic send_particle(input req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.path_ct <= p.path_ct;
      req_chan.mom_x_in <= p.mom_x_in;
      req_chan.mom_y_in <= p.mom_y_in;
      req_chan.lost_in <= p.lost_in;
      do @(posedge clock); while (!req_chan.ready);
      kicked_momenta.push_back(kick_particle(p));
   endtask

   // Every request yields exactly one response, so the core is idle once the
   // queue of predictions is empty; the watchdog bounds the wait.
   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      while (kicked_momenta.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic report_mismatch(input string what,
                                  input logic [FIELD_W-1:0] got,
                                  input logic [FIELD_W-1:0] want);
      if (mismatches < PRINT_LIMIT) begin
         $display("mismatch at %0t: %s, got %h, expected %h", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // The sink stalls at the current response-side rate; with a rate of zero
   // ready stays high.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Each accepted response is matched against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (kicked_momenta.size() == 0) begin
            report_mismatch("response with no request pending", rsp_chan.mom_x_out, '0);
         end else begin
            want = kicked_momenta.pop_front();
            if (rsp_chan.mom_x_out !== want.mom_x_out) begin
               report_mismatch("mom_x_out", rsp_chan.mom_x_out, want.mom_x_out);
            end
            if (rsp_chan.mom_y_out !== want.mom_y_out) begin
               report_mismatch("mom_y_out", rsp_chan.mom_y_out, want.mom_y_out);
            end
            if (rsp_chan.lost_out !== want.lost_out) begin
               report_mismatch("lost_out", FIELD_W'(rsp_chan.lost_out),
                               FIELD_W'(want.lost_out));
            end
         end
      end
   end

   // Ends the run if no channel completes a handshake for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // With every register still at its reset value of zero the kick is zero,
   // so the momenta must come back unchanged even at the rails.
   task automatic test_reset_state();
      send_particle(particle(WORD_MAX, WORD_MAX, WORD_MIN, 1'b0));
      send_particle(particle(WORD_MIN, WORD_MIN, WORD_MAX, 1'b0));
      wait_until_drained();
   endtask

   // Phases sit exactly on a quarter turn, so the sine is close to +1 or -1
   // and a full-scale kick pushes rail momenta past the rails. Lost
   // particles in the same setting must not be kicked or clipped.
   task automatic test_saturation_and_lost();
      program_registers(cfg_type'{kick_x: WORD_MAX, kick_y: WORD_MIN,
                                  phase_x: QUARTER_WORD, phase_y: QUARTER_WORD,
                                  wavenumber_x: WORD_ZERO, wavenumber_y: WORD_ZERO});
      send_particle(particle(WORD_ZERO, WORD_MAX, WORD_MIN, 1'b0));
      send_particle(particle(WORD_ZERO, WORD_MAX, WORD_MIN, 1'b1));
      send_particle(particle(WORD_ZERO, WORD_ZERO, WORD_ZERO, 1'b0));
      send_particle(particle(WORD_ZERO, WORD_MIN, WORD_MAX, 1'b0));
      send_particle(particle(WORD_ONES, WORD_ONES, 32'h0000_0001, 1'b1));
      wait_until_drained();
      program_registers(cfg_type'{kick_x: WORD_MAX, kick_y: WORD_MIN,
                                  phase_x: THREE_QUARTER_WORD, phase_y: THREE_QUARTER_WORD,
                                  wavenumber_x: WORD_ZERO, wavenumber_y: WORD_ZERO});
      send_particle(particle(WORD_ZERO, WORD_MIN, WORD_MAX, 1'b0));
      wait_until_drained();
   endtask

   // At one cycle per metre the fraction of ct steps the angle directly. The
   // x phase is one unit above zero and the y wavenumber is negated with a
   // phase one unit below zero, so the angles land one unit either side of a
   // quarter turn and of half a turn, and both fold branches are taken.
   task automatic test_quadrant_folds();
      program_registers(cfg_type'{kick_x: QUARTER_WORD, kick_y: QUARTER_WORD,
                                  phase_x: 32'h0000_0001, phase_y: WORD_ONES,
                                  wavenumber_x: ONE_PER_METRE,
                                  wavenumber_y: -ONE_PER_METRE});
      send_particle(particle(32'h0000_C000, $urandom, $urandom, 1'b0));
      send_particle(particle(32'h0001_4000, $urandom, $urandom, 1'b0));
      send_particle(particle(32'hFFFF_8000, $urandom, $urandom, 1'b0));
      send_particle(particle(WORD_ZERO, $urandom, $urandom, 1'b0));
      send_particle(particle(32'h7FFF_C000, $urandom, $urandom, 1'b0));
      send_particle(particle(32'h8000_4000, $urandom, $urandom, 1'b0));
      wait_until_drained();
   endtask

   // The extreme wavenumbers against extreme ct give the largest products,
   // whose bits above the offset field are dropped; unit ct is sent as well.
   task automatic test_product_extremes();
      program_registers(cfg_type'{kick_x: WORD_MIN, kick_y: WORD_MAX,
                                  phase_x: WORD_ZERO, phase_y: WORD_ONES,
                                  wavenumber_x: WORD_MAX, wavenumber_y: WORD_MIN});
      send_particle(particle(WORD_MAX, random_momentum(), random_momentum(), 1'b0));
      send_particle(particle(WORD_MIN, random_momentum(), random_momentum(), 1'b0));
      send_particle(particle(WORD_ONES, random_momentum(), random_momentum(), 1'b0));
      send_particle(particle(32'h0000_0001, random_momentum(), random_momentum(), 1'b0));
      wait_until_drained();
   endtask

   // Random bursts, each under its own register setting, with the given
   // idling rates on the two sides.
   task automatic test_random_traffic(input int unsigned send_pct,
                                      input int unsigned stall_pct,
                                      input int unsigned count);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int unsigned burst = 0; burst < count / BURST_LEN; burst++) begin
         program_registers(random_settings(burst));
         repeat (BURST_LEN) send_particle(random_particle());
         wait_until_drained();
      end
   endtask

   initial begin
      // Every input is known from time zero while reset is held.
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.path_ct = '0;
      req_chan.mom_x_in = '0;
      req_chan.mom_y_in = '0;
      req_chan.lost_in = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_KICK_X;
      csr_chan.data = '0;
      csr_shadow = '0;
      mismatches = 0;
      send_idle_pct = 21;
      rsp_stall_pct = 49;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_saturation_and_lost();
      test_quadrant_folds();
      test_product_extremes();

      test_random_traffic(21, 49, 550);
      test_random_traffic(49, 21, 550);
      test_random_traffic(0, 0, 550);

      // Give a stray extra response time to show up before judging.
      wait_until_drained();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (kicked_momenta.size() != 0) begin
         report_mismatch("requests left without a response", kicked_momenta.size(), '0);
      end
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
